>>> design/sphs_pkg.sv
// ----------------------------------------------------------------------------
// sphs_pkg
// Shared constants, codes and types of the spectrum peak-hold store.
// ----------------------------------------------------------------------------
package sphs_pkg;

    localparam int BIN_COUNT  = 4096;
    localparam int BIN_W      = $clog2(BIN_COUNT);
    localparam int LEVEL_W    = 16;
    localparam int FREQ_W     = 32;
    localparam int PROD_W     = 2 * FREQ_W;
    localparam int SCALE_FRAC = 16;
    localparam int CFG_W      = 2;

    // -150 dB and -120 dB in 1/128 dB steps
    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = LEVEL_W'(-19200);
    localparam logic [LEVEL_W-1:0] LEVEL_MISS  = LEVEL_W'(-15360);

    localparam logic [CFG_W-1:0] CFG_FREQ_LOW  = CFG_W'(0);
    localparam logic [CFG_W-1:0] CFG_FREQ_HIGH = CFG_W'(1);
    localparam logic [CFG_W-1:0] CFG_BIN_SCALE = CFG_W'(2);

    localparam logic [FREQ_W-1:0] FREQ_LOW_RST  = '0;
    localparam logic [FREQ_W-1:0] FREQ_HIGH_RST = '1;
    localparam logic [FREQ_W-1:0] BIN_SCALE_RST = FREQ_W'(65536);

    typedef enum logic [1:0] {
        ACT_WRITE      = 2'd0,
        ACT_READ_LEVEL = 2'd1,
        ACT_READ_PEAK  = 2'd2,
        ACT_COPY_PEAK  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_LOOK,
        ST_DONE,
        ST_COPY,
        ST_COPY_END
    } t_state;

endpackage

>>> design/sphs_ram.sv
// ----------------------------------------------------------------------------
// sphs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sphs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/spectrum_peak_hold_store_top.sv
// ----------------------------------------------------------------------------
// spectrum_peak_hold_store_top
// Spectrum bin store with peak hold: current level and peak level per bin.
// ----------------------------------------------------------------------------
// A point transaction (write / read level / read peak) passes MAP (multiply),
//   LOOK (RAM read) and DONE (read-modify-write of the peak) with o_busy high;
//   o_done is registered from DONE, and the next one can be taken with the strobe.
// Peak reset walks all BIN_COUNT bins one per cycle, then passes COPY_END and
//   DONE with o_busy high. o_done is a one-cycle strobe; no receiver stall.
// Reset: synchronous, active low; then both RAMs are swept to -150 dB, one bin
//   per cycle with o_busy high; config writes are taken.
module spectrum_peak_hold_store_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [1:0]                           i_action,
    input  logic [sphs_pkg::FREQ_W-1:0]          i_freq,
    input  logic signed [sphs_pkg::LEVEL_W-1:0]  i_level_in,
    input  logic                                 i_cfg_we,
    input  logic [sphs_pkg::CFG_W-1:0]           i_cfg_idx,
    input  logic [sphs_pkg::FREQ_W-1:0]          i_cfg_data,
    output logic                                 o_busy,
    output logic                                 o_done,
    output logic signed [sphs_pkg::LEVEL_W-1:0]  o_level_out,
    output logic                                 o_status
);

    localparam int HI_W = sphs_pkg::PROD_W - sphs_pkg::SCALE_FRAC;

    // control state
    sphs_pkg::t_state              r_state, n_state;
    logic [sphs_pkg::BIN_W-1:0]    r_idx, n_idx;
    logic                          r_cp_we, n_cp_we;
    logic                          r_done, n_done;

    // config registers
    logic [sphs_pkg::FREQ_W-1:0]   r_freq_low, r_freq_high, r_bin_scale;

    // transaction payload
    sphs_pkg::t_action             r_action;
    logic [sphs_pkg::FREQ_W-1:0]   r_freq;
    logic [sphs_pkg::LEVEL_W-1:0]  r_level;
    logic [sphs_pkg::PROD_W-1:0]   r_prod;
    logic                          r_fr_ok;
    logic                          r_ok;
    logic [sphs_pkg::BIN_W-1:0]    r_cp_addr;
    logic [sphs_pkg::LEVEL_W-1:0]  r_level_out, n_level_out;
    logic                          r_status, n_status;

    // RAM ports
    logic                          lvl_we, pk_we;
    logic [sphs_pkg::BIN_W-1:0]    lvl_waddr, lvl_raddr, pk_waddr, pk_raddr;
    logic [sphs_pkg::LEVEL_W-1:0]  lvl_wdata, pk_wdata, lvl_rdata, pk_rdata;

    logic                          w_accept;
    logic                          w_last;
    logic [sphs_pkg::BIN_W-1:0]    w_bin;
    logic                          w_wr_ok;
    logic                          w_raise;

    assign w_accept = i_start && (r_state == sphs_pkg::ST_IDLE);
    assign w_last   = (r_idx == sphs_pkg::BIN_W'(sphs_pkg::BIN_COUNT - 1));
    // bin = (freq * scale) >> 16, low bits; range is checked on the full value
    assign w_bin    = r_prod[sphs_pkg::SCALE_FRAC +: sphs_pkg::BIN_W];
    assign w_wr_ok  = (r_action == sphs_pkg::ACT_WRITE) && r_ok;
    assign w_raise  = $signed(pk_rdata) < $signed(r_level);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sphs_pkg::ST_CLEAR: begin
                if (w_last) n_state = sphs_pkg::ST_IDLE;
            end
            sphs_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (sphs_pkg::t_action'(i_action) == sphs_pkg::ACT_COPY_PEAK)
                              ? sphs_pkg::ST_COPY : sphs_pkg::ST_MAP;
                end
            end
            sphs_pkg::ST_MAP:      n_state = sphs_pkg::ST_LOOK;
            sphs_pkg::ST_LOOK:     n_state = sphs_pkg::ST_DONE;
            sphs_pkg::ST_DONE:     n_state = sphs_pkg::ST_IDLE;
            sphs_pkg::ST_COPY: begin
                if (w_last) n_state = sphs_pkg::ST_COPY_END;
            end
            sphs_pkg::ST_COPY_END: n_state = sphs_pkg::ST_DONE;
            default:               n_state = sphs_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs of the FSM ----------------
    always_comb begin
        lvl_we      = 1'b0;
        lvl_waddr   = w_bin;
        lvl_wdata   = r_level;
        lvl_raddr   = w_bin;
        pk_we       = 1'b0;
        pk_waddr    = w_bin;
        pk_wdata    = r_level;
        pk_raddr    = w_bin;
        n_idx       = '0;
        n_cp_we     = 1'b0;
        n_done      = 1'b0;
        n_level_out = '0;
        n_status    = 1'b0;

        unique case (r_state)
            sphs_pkg::ST_CLEAR: begin
                // power-up sweep of both stores to the floor level
                lvl_we    = 1'b1;
                lvl_waddr = r_idx;
                lvl_wdata = sphs_pkg::LEVEL_FLOOR;
                pk_we     = 1'b1;
                pk_waddr  = r_idx;
                pk_wdata  = sphs_pkg::LEVEL_FLOOR;
                n_idx     = w_last ? '0 : r_idx + 1'b1;
            end
            sphs_pkg::ST_COPY: begin
                // read level[idx] now, write peak[idx] next cycle
                lvl_raddr = r_idx;
                n_cp_we   = 1'b1;
                n_idx     = w_last ? '0 : r_idx + 1'b1;
                pk_we     = r_cp_we;
                pk_waddr  = r_cp_addr;
                pk_wdata  = lvl_rdata;
            end
            sphs_pkg::ST_COPY_END: begin
                pk_we    = r_cp_we;
                pk_waddr = r_cp_addr;
                pk_wdata = lvl_rdata;
            end
            sphs_pkg::ST_DONE: begin
                // read data of the looked-up bin is valid here
                n_done = 1'b1;
                lvl_we = w_wr_ok;
                pk_we  = w_wr_ok && w_raise;
                unique case (r_action)
                    sphs_pkg::ACT_WRITE: begin
                        n_status = !r_ok;
                    end
                    sphs_pkg::ACT_READ_LEVEL: begin
                        n_level_out = r_ok ? lvl_rdata : sphs_pkg::LEVEL_MISS;
                        n_status    = !r_ok;
                    end
                    sphs_pkg::ACT_READ_PEAK: begin
                        n_level_out = r_ok ? pk_rdata : sphs_pkg::LEVEL_MISS;
                        n_status    = !r_ok;
                    end
                    sphs_pkg::ACT_COPY_PEAK: begin
                        n_status = 1'b0;
                    end
                    default: begin
                        n_status = 1'b0;
                    end
                endcase
            end
            sphs_pkg::ST_IDLE, sphs_pkg::ST_MAP, sphs_pkg::ST_LOOK: begin
                n_idx = '0;
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sphs_pkg::ST_CLEAR;
            r_idx   <= '0;
            r_cp_we <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cp_we <= n_cp_we;
            r_done  <= n_done;
        end
    end

    // ---------------- config registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_low  <= sphs_pkg::FREQ_LOW_RST;
            r_freq_high <= sphs_pkg::FREQ_HIGH_RST;
            r_bin_scale <= sphs_pkg::BIN_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sphs_pkg::CFG_FREQ_LOW:  r_freq_low  <= i_cfg_data;
                sphs_pkg::CFG_FREQ_HIGH: r_freq_high <= i_cfg_data;
                sphs_pkg::CFG_BIN_SCALE: r_bin_scale <= i_cfg_data;
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= sphs_pkg::t_action'(i_action);
            r_freq   <= i_freq;
            r_level  <= i_level_in;
        end
        if (r_state == sphs_pkg::ST_MAP) begin
            // 32x32 full-width product, Q16.16 scale
            r_prod  <= sphs_pkg::PROD_W'(r_freq) * sphs_pkg::PROD_W'(r_bin_scale);
            r_fr_ok <= (r_freq > r_freq_low) && (r_freq < r_freq_high);
        end
        if (r_state == sphs_pkg::ST_LOOK) begin
            r_ok <= r_fr_ok
                    && (r_prod[sphs_pkg::PROD_W-1:sphs_pkg::SCALE_FRAC]
                        < HI_W'(sphs_pkg::BIN_COUNT));
        end
        r_cp_addr   <= r_idx;
        r_level_out <= n_level_out;
        r_status    <= n_status;
    end

    sphs_ram #(
        .WIDTH (sphs_pkg::LEVEL_W),
        .DEPTH (sphs_pkg::BIN_COUNT)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    sphs_ram #(
        .WIDTH (sphs_pkg::LEVEL_W),
        .DEPTH (sphs_pkg::BIN_COUNT)
    ) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (pk_we),
        .i_waddr (pk_waddr),
        .i_wdata (pk_wdata),
        .i_raddr (pk_raddr),
        .o_rdata (pk_rdata)
    );

    assign o_busy      = (r_state != sphs_pkg::ST_IDLE);
    assign o_done      = r_done;
    assign o_level_out = r_level_out;
    assign o_status    = r_status;

endmodule

>>> design/sphs_chk.sv
// ----------------------------------------------------------------------------
// sphs_chk
// Port-level checks of the spectrum peak-hold store, bound to the top level.
// ----------------------------------------------------------------------------
module sphs_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic                         o_done,
    input logic [sphs_pkg::LEVEL_W-1:0] o_level_out,
    input logic                         o_status
);

    // a taken transaction makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted transaction did not raise busy");

    // the result strobe follows the last busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_busy && $past(o_busy)))
        else $error("result strobe outside the end of a transaction");

    // strobes never come back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    // a flagged result carries either zero (write) or the miss level (read)
    a_flag_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |->
            ((o_level_out == '0) || (o_level_out == sphs_pkg::LEVEL_MISS)))
        else $error("out-of-range result with unexpected level");

endmodule

bind spectrum_peak_hold_store_top sphs_chk u_sphs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_level_out (o_level_out),
    .o_status    (o_status)
);
